// ===== sv/lrf_pkg.sv =====
package lrf_pkg;

   localparam int SAMPLE_BITS = 16;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_value;
      logic signed [SAMPLE_BITS-1:0] y_value;
      logic                          last_pair;
   } req_type;

   typedef struct packed {
      logic signed [47:0] slope;
      logic signed [47:0] intercept;
      logic signed [15:0] correlation;
      logic [10:0]        pairs_used;
      logic [1:0]         fit_status;
   } rsp_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_X_CONST  = 2'd1;
   localparam logic [1:0] STATUS_Y_CONST  = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

endpackage

// ===== sv/linear_regression_fit.sv =====
// Least-squares line fit over a stream of (x, y) pairs. Each pair is taken while the block is idle
// and added to exact running sums; a pair flagged last_pair closes the set. The block then
// stalls its input while one shared bit-serial 64x64 multiplier forms up to eleven products,
// a shift-subtract loop forms r squared, a 16-step square root forms |r|, and one restoring
// divider gives slope and intercept in Q31.16; after that the result is posted and the sums are
// cleared. Pairs beyond MAX_POINTS are dropped and flagged with fit_status 3.
module linear_regression_fit #(
   parameter int MAX_POINTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lrf_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lrf_pkg::rsp_type rsp_payload
);
   import lrf_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SX_W  = SAMPLE_BITS + CNT_W;
   localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_POST  = 4'd3;
   localparam logic [3:0] ST_RATIO = 4'd4;
   localparam logic [3:0] ST_SQRT  = 4'd5;
   localparam logic [3:0] ST_DLOAD = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_DEND  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   localparam logic [3:0] SP_NXX = 4'd0;
   localparam logic [3:0] SP_XX  = 4'd1;
   localparam logic [3:0] SP_NYY = 4'd2;
   localparam logic [3:0] SP_YY  = 4'd3;
   localparam logic [3:0] SP_NXY = 4'd4;
   localparam logic [3:0] SP_XY  = 4'd5;
   localparam logic [3:0] SP_SS  = 4'd6;
   localparam logic [3:0] SP_PP  = 4'd7;
   localparam logic [3:0] SP_H0  = 4'd8;
   localparam logic [3:0] SP_H1  = 4'd9;
   localparam logic [3:0] SP_DEN = 4'd10;

   localparam logic [127:0] LIM_POS = 128'(64'h0000_7FFF_FFFF_FFFF);
   localparam logic [127:0] LIM_NEG = 128'(64'h0000_8000_0000_0000);

   logic [3:0] state_ff, state_in, step_ff, step_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [SX_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [SQ_W-1:0] sx2_ff, sx2_in, sy2_ff, sy2_in;
   logic signed [SQ_W:0] sxy_ff, sxy_in;
   logic ovf_ff, ovf_in;
   logic [127:0] mula_ff, mula_in, acc_ff, acc_in;
   logic [63:0] mulb_ff, mulb_in;
   logic mneg_ff, mneg_in;
   logic [63:0] t0_ff, t0_in, sxx_ff, sxx_in, syy_ff, syy_in, dxy_ff, dxy_in;
   logic [1:0] status_ff, status_in;
   logic [127:0] s_ff, s_in, p_ff, p_in, hn_ff, hn_in;
   logic [30:0] t_ff, t_in;
   logic [15:0] root_ff, root_in, corr_ff, corr_in;
   logic [3:0] bit_ff, bit_in;
   logic [63:0] dh_ff, dh_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [127:0] dq_ff, dq_in;
   logic dneg_ff, dneg_in, dsel_ff, dsel_in;
   logic [47:0] slope_ff, slope_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [SAMPLE_BITS-1:0] xs, ys;
   logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
   logic [63:0] n64, opa, opb;
   logic [127:0] prod, s2, num, nmag, qv, mv;
   logic [64:0] r2;
   logic [15:0] cand;
   logic [31:0] csq;
   logic [47:0] sat;

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? 64'(0) - v : v;
   endfunction

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign xs   = SAMPLE_BITS'(req_payload.x_value);
   assign ys   = SAMPLE_BITS'(req_payload.y_value);
   assign xx   = xs * xs;
   assign yy   = ys * ys;
   assign xy   = xs * ys;
   assign n64  = 64'(count_ff);
   assign prod = mneg_ff ? 128'(0) - acc_ff : acc_ff;
   assign s2   = s_ff << 1;
   assign r2   = {dr_ff, dq_ff[127]};
   assign cand = root_ff | (16'(1) << bit_ff);
   assign csq  = 32'(cand) * 32'(cand);
   assign num  = dsel_ff ? hn_ff : {{64{dxy_ff[63]}}, dxy_ff};
   assign nmag = num[127] ? 128'(0) - num : num;
   assign qv   = (dd_ff == 64'(0)) ? '1 : dq_ff;
   assign mv   = dneg_ff ? ((qv > LIM_NEG) ? LIM_NEG : qv) : ((qv > LIM_POS) ? LIM_POS : qv);
   assign sat  = dneg_ff ? 48'(0) - mv[47:0] : mv[47:0];

   always_comb begin
      case (step_ff)
         SP_NXX:  begin opa = n64;               opb = 64'(sx2_ff);     end
         SP_XX:   begin opa = 64'(sx_ff);        opb = 64'(sx_ff);      end
         SP_NYY:  begin opa = n64;               opb = 64'(sy2_ff);     end
         SP_YY:   begin opa = 64'(sy_ff);        opb = 64'(sy_ff);      end
         SP_NXY:  begin opa = n64;               opb = 64'(sxy_ff);     end
         SP_XY:   begin opa = 64'(sx_ff);        opb = 64'(sy_ff);      end
         SP_SS:   begin opa = dxy_ff;            opb = dxy_ff;          end
         SP_PP:   begin opa = sxx_ff;            opb = syy_ff;          end
         SP_H0:   begin opa = 64'(sy_ff);        opb = sxx_ff;          end
         SP_H1:   begin opa = dxy_ff;            opb = 64'(sx_ff);      end
         SP_DEN:  begin opa = n64;               opb = sxx_ff;          end
         default: begin opa = 64'(0);            opb = 64'(0);          end
      endcase
   end

   always_comb begin
      state_in = state_ff;   step_in = step_ff;   cnt_in = cnt_ff;
      count_in = count_ff;   sx_in = sx_ff;       sy_in = sy_ff;
      sx2_in = sx2_ff;       sy2_in = sy2_ff;     sxy_in = sxy_ff;   ovf_in = ovf_ff;
      mula_in = mula_ff;     mulb_in = mulb_ff;   acc_in = acc_ff;   mneg_in = mneg_ff;
      t0_in = t0_ff;         sxx_in = sxx_ff;     syy_in = syy_ff;   dxy_in = dxy_ff;
      status_in = status_ff; s_in = s_ff;         p_in = p_ff;       hn_in = hn_ff;
      t_in = t_ff;           root_in = root_ff;   corr_in = corr_ff; bit_in = bit_ff;
      dh_in = dh_ff;         dr_in = dr_ff;       dd_in = dd_ff;     dq_in = dq_ff;
      dneg_in = dneg_ff;     dsel_in = dsel_ff;   slope_in = slope_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  count_in = count_ff + CNT_W'(1);
                  sx_in    = sx_ff + SX_W'(xs);
                  sy_in    = sy_ff + SX_W'(ys);
                  sx2_in   = sx2_ff + SQ_W'($unsigned(xx));
                  sy2_in   = sy2_ff + SQ_W'($unsigned(yy));
                  sxy_in   = sxy_ff + (SQ_W + 1)'(xy);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.last_pair) begin
                  step_in  = SP_NXX;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            mula_in  = {64'(0), mag64(opa)};
            mulb_in  = mag64(opb);
            mneg_in  = opa[63] ^ opb[63];
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mulb_ff[0]) acc_in = acc_ff + mula_ff;
            mula_in = mula_ff << 1;
            mulb_in = mulb_ff >> 1;
            cnt_in  = cnt_ff + 7'(1);
            if (cnt_ff == 7'd63) state_in = ST_POST;
         end
         ST_POST: begin
            state_in = ST_LOAD;
            step_in  = step_ff + 4'(1);
            case (step_ff)
               SP_NXX, SP_NYY, SP_NXY: t0_in = prod[63:0];
               SP_XX: sxx_in = t0_ff - prod[63:0];
               SP_YY: syy_in = t0_ff - prod[63:0];
               SP_XY: begin
                  dxy_in = t0_ff - prod[63:0];
                  corr_in = '0;
                  if (sxx_ff == 64'(0)) begin
                     status_in = STATUS_X_CONST;
                     sxx_in    = 64'(1);
                     dxy_in    = '0;
                     step_in   = SP_H0;
                  end else if (syy_ff == 64'(0)) begin
                     status_in = STATUS_Y_CONST;
                     dxy_in    = '0;
                     step_in   = SP_H0;
                  end else begin
                     status_in = STATUS_OK;
                  end
               end
               SP_SS: s_in = prod;
               SP_PP: begin
                  p_in    = prod;
                  step_in = SP_H0;
                  root_in = '0;
                  bit_in  = 4'd15;
                  cnt_in  = '0;
                  if (s_ff >= prod) begin
                     t_in     = 31'(1) << 30;
                     state_in = ST_SQRT;
                  end else begin
                     t_in     = '0;
                     state_in = ST_RATIO;
                  end
               end
               SP_H0: hn_in = prod;
               SP_H1: hn_in = hn_ff - prod;
               SP_DEN: begin
                  dh_in    = prod[63:0];
                  dsel_in  = 1'b0;
                  state_in = ST_DLOAD;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RATIO: begin
            // one quotient bit of dxy^2 / (sxx*syy) per cycle
            if (s2 >= p_ff) begin
               s_in = s2 - p_ff;
               t_in = {t_ff[29:0], 1'b1};
            end else begin
               s_in = s2;
               t_in = {t_ff[29:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'(1);
            if (cnt_ff == 7'd29) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (csq <= 32'(t_ff)) root_in = cand;
            bit_in = bit_ff - 4'(1);
            if (bit_ff == 4'd0) begin
               if (csq <= 32'(t_ff)) begin
                  corr_in = (cand > 16'd32767) ? 16'd32767 : cand;
               end else begin
                  corr_in = (root_ff > 16'd32767) ? 16'd32767 : root_ff;
               end
               if (dxy_ff[63]) corr_in = 16'(0) - corr_in;
               state_in = ST_LOAD;
            end
         end
         ST_DLOAD: begin
            dneg_in  = num[127];
            dq_in    = nmag << 16;
            dr_in    = '0;
            dd_in    = dsel_ff ? dh_ff : sxx_ff;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (r2 >= {1'b0, dd_ff}) begin
               dr_in = 64'(r2 - {1'b0, dd_ff});
               dq_in = {dq_ff[126:0], 1'b1};
            end else begin
               dr_in = r2[63:0];
               dq_in = {dq_ff[126:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'(1);
            if (cnt_ff == 7'd127) state_in = ST_DEND;
         end
         ST_DEND: begin
            if (!dsel_ff) begin
               slope_in = sat;
               dsel_in  = 1'b1;
               state_in = ST_DLOAD;
            end else begin
               hn_in    = 128'($signed(sat));
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the previous transaction has drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.slope       = slope_ff;
               rsp_in.intercept   = hn_ff[47:0];
               rsp_in.correlation = corr_ff;
               rsp_in.pairs_used  = n64[10:0];
               rsp_in.fit_status  = ovf_ff ? STATUS_OVERFLOW : status_ff;
               rsp_valid_in = 1'b1;
               count_in = '0;  sx_in = '0;  sy_in = '0;
               sx2_in = '0;    sy2_in = '0; sxy_in = '0;  ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= SP_NXX;
         cnt_ff       <= '0;
         count_ff     <= '0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sx2_ff       <= '0;
         sy2_ff       <= '0;
         sxy_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         sx2_ff       <= sx2_in;
         sy2_ff       <= sy2_in;
         sxy_ff       <= sxy_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mula_ff <= mula_in;   mulb_ff <= mulb_in;   acc_ff <= acc_in;   mneg_ff <= mneg_in;
      t0_ff <= t0_in;       sxx_ff <= sxx_in;     syy_ff <= syy_in;   dxy_ff <= dxy_in;
      status_ff <= status_in;
      s_ff <= s_in;         p_ff <= p_in;         hn_ff <= hn_in;
      t_ff <= t_in;         root_ff <= root_in;   corr_ff <= corr_in; bit_ff <= bit_in;
      dh_ff <= dh_in;       dr_ff <= dr_in;       dd_ff <= dd_in;     dq_ff <= dq_in;
      dneg_ff <= dneg_in;   dsel_ff <= dsel_in;   slope_ff <= slope_in;
      rsp_ff <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("pair count exceeds MAX_POINTS");

   a_cleared_after_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> (count_ff == '0 && !ovf_ff))
      else $error("sums not cleared after fit");

   a_post_raises_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |=> rsp_valid)
      else $error("finished fit not posted");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule
